@@ hw/rtl/slt_pkg.sv @@
`timescale 1ns / 1ps

package slt_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int KEY_W            = 32;
   localparam int POS_W            = 5;
   localparam int STATUS_W         = 3;
   localparam int CMD_W            = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // per-cycle command to every cell of the row
   typedef struct packed {
      logic cmp;   // compare held value against the key
      logic ins;   // open a gap and drop the key in
      logic del;   // close the gap left by the first equal entry
   } cell_ctrl_type;

endpackage

@@ hw/rtl/slt_cell.sv @@
`timescale 1ns / 1ps

// One slot of the sorted row: holds one key and its compare flags.
module slt_cell import slt_pkg::*; (
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic signed [KEY_W-1:0] key,
   input  logic                    valid,       // slot holds an entry
   input  logic                    left_le,     // left neighbor <= key (1 for slot 0)
   input  logic signed [KEY_W-1:0] left_value,
   input  logic signed [KEY_W-1:0] right_value,
   output logic signed [KEY_W-1:0] value_out,
   output logic                    lt_out,
   output logic                    le_out
);

   logic signed [KEY_W-1:0] value_ff, value_in;
   logic                    lt_ff, lt_in;
   logic                    le_ff, le_in;

   always_comb begin
      value_in = value_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      if (ctrl.cmp) begin
         lt_in = valid && (value_ff < key);
         le_in = valid && (value_ff <= key);
      end
      if (ctrl.ins) begin
         // slots at or past the insert point move right; the first one takes the key
         if (!le_ff) begin
            value_in = left_le ? key : left_value;
         end
      end else if (ctrl.del) begin
         // slots from the matched entry on pull from the right
         if (!lt_ff) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      le_ff    <= le_in;
   end

   assign value_out = value_ff;
   assign lt_out    = lt_ff;
   assign le_out    = le_ff;

endmodule

@@ hw/rtl/sorted_list_table.sv @@
`timescale 1ns / 1ps

// Sorted key table: a row of CAPACITY cells holding signed 32-bit keys in
// ascending order. Each request transaction carries a command (insert,
// search, delete) and a key; each produces exactly one response transaction
// with status, 1-based position and the entry count after the command.
//   req_tdata : [1:0] cmd, [33:2] value, [39:34] zero
//   rsp_tdata : [2:0] status, [7:3] position, [12:8] count, [15:13] zero
// Steps: a command goes through accept, compare (every cell compares its
// held value against the key in parallel and registers lt/le flags) and
// update (an insert shifts the row one slot right, a delete one slot left,
// and the response register loads). A new command is accepted only after
// the previous one has left its update step, as the single cell row serves
// one command at a time. A new request is taken while the previous response
// still waits in the output register.
// A stalled receiver holds the response; a command reaching its update step
// waits there, with the row untouched, until the output register frees up.
// Reset (synchronous, active high) empties the table (count to zero) and
// drops any pending response; the key store itself is not cleared.
module sorted_list_table import slt_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cmd[1:0], value[33:2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[2:0], position[7:3], count[12:8], zero pad
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_UPD  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]           count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]        rsp_count_ff, rsp_count_in;

   cell_ctrl_type           ctrl;
   logic signed [KEY_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]     lt_vec;
   logic [CAPACITY-1:0]     le_vec;
   logic [CAPACITY-1:0]     eq_vec;
   logic [CAPACITY-1:0]     valid_vec;

   logic                    go;
   logic                    full;
   logic                    found;
   logic [CW-1:0]           idx_le;
   logic [CW-1:0]           idx_lt;
   logic [CW:0]             pos_full;
   logic [CW+POS_W:0]       pos_pad;
   logic [CW+POS_W-1:0]     count_pad;

   // index one past the last set flag of a thermometer vector (0 if none)
   function automatic logic [CW-1:0] thermo_len(input logic [CAPACITY-1:0] flags);
      logic [CAPACITY:0] ext;
      logic [CW-1:0]     len;
      ext = {1'b0, flags};
      len = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ext[i] && !ext[i+1]) begin
            len = len | CW'(i + 1);
         end
      end
      return len;
   endfunction

   // ---------------------------------------------------------------- cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_W-1:0] left_value;
      logic signed [KEY_W-1:0] right_value;
      logic                    left_le;

      if (g == 0) begin : g_first
         assign left_value = cell_value[g];
         assign left_le    = 1'b1;
      end else begin : g_mid
         assign left_value = cell_value[g-1];
         assign left_le    = le_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner
         assign right_value = cell_value[g+1];
      end

      assign valid_vec[g] = count_ff > CW'(g);

      slt_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key         (key_ff),
         .valid       (valid_vec[g]),
         .left_le     (left_le),
         .left_value  (left_value),
         .right_value (right_value),
         .value_out   (cell_value[g]),
         .lt_out      (lt_vec[g]),
         .le_out      (le_vec[g])
      );
   end

   // ------------------------------------------------------------- decode
   assign eq_vec = le_vec & ~lt_vec;
   assign found  = |eq_vec;
   assign full   = count_ff == CW'(CAPACITY);
   assign idx_le = thermo_len(le_vec);   // insert point
   assign idx_lt = thermo_len(lt_vec);   // first equal entry, when found

   // update step may fire only when the output register can take the result
   assign go = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      pos_full      = '0;
      ctrl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tdata[CMD_W-1:0];
               key_in   = $signed(req_tdata[CMD_W+KEY_W-1:CMD_W]);
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctrl.cmp = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = S_IDLE;
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.ins      = 1'b1;
                        rsp_status_in = ST_INSERTED;
                        pos_full      = {1'b0, idx_le} + 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     if (found) begin
                        rsp_status_in = ST_FOUND;
                        pos_full      = {1'b0, idx_lt} + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (found) begin
                        ctrl.del      = 1'b1;
                        rsp_status_in = ST_DELETED;
                        pos_full      = {1'b0, idx_lt} + 1'b1;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  default: begin
                     // unused command code: no change, reported as not found
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // low five bits of position and count, whatever CAPACITY is
   assign pos_pad      = {{POS_W{1'b0}}, pos_full};
   assign count_pad    = {{POS_W{1'b0}}, count_in};
   assign rsp_pos_in   = pos_pad[POS_W-1:0];
   assign rsp_count_in = count_pad[POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      if (go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_pos_ff, rsp_status_ff};

   // ------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_flags_sorted: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD |->
         ((lt_vec & ~le_vec) == '0) &&
         (((le_vec + {{(CAPACITY-1){1'b0}}, 1'b1}) & le_vec) == '0))
      else $error("compare flags not a prefix: row out of order");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      go && ctrl.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the table by one");

endmodule
